// ----- sv/rqps_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rqps_pkg: shared types and constants of the ready queue policy select block
// Queue sizing, field widths, operation and status codes, and the command and
// status groups that pass between the controller and the datapath.
// ============================================================================
package rqps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int URG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int POLICY_W = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_SELECT  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SELECTED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

    localparam logic [POLICY_W-1:0] POLICY_RR       = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_SRT      = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_PRIO     = 2'd2;
    localparam logic [POLICY_W-1:0] POLICY_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLICE  = 1'd1;

    localparam logic [TIME_W-1:0] TIME_SLICE_RESET = 16'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } rqps_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } rqps_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic out_free;
    } rqps_stat_t;

endpackage

// ----- sv/rqps_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rqps_ctrl: sequencing controller of the ready queue
// Accepts one transaction at a time, steps the datapath through the policy
// scan when one is needed, and commits once the result register is free.
// ============================================================================
module rqps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rqps_pkg::rqps_stat_t stat,
    output rqps_pkg::rqps_cmd_t  cmd
);
    import rqps_pkg::*;

    rqps_state_t state_reg;
    rqps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.needs_scan ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/rqps_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rqps_datapath: task slots, policy scan and result register
// Holds the queued tasks in order, walks them one per cycle to find the
// winner under the active policy, compacts the slots on removal and drives
// the result register.
// ============================================================================
module rqps_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rqps_pkg::rqps_cmd_t                cmd,
    output rqps_pkg::rqps_stat_t               stat,
    input  logic                               cfg_we,
    input  logic [rqps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rqps_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               kind,
    input  logic [rqps_pkg::ID_W-1:0]          task_id,
    input  logic [rqps_pkg::TIME_W-1:0]        time_left,
    input  logic [rqps_pkg::URG_W-1:0]         urgency,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rqps_pkg::STATUS_W-1:0]      status,
    output logic [rqps_pkg::ID_W-1:0]          chosen_id,
    output logic [rqps_pkg::TIME_W-1:0]        chosen_time,
    output logic [rqps_pkg::URG_W-1:0]         chosen_urgency,
    output logic [rqps_pkg::TIME_W-1:0]        granted_slice,
    output logic [rqps_pkg::OCC_W-1:0]         occupancy
);
    import rqps_pkg::*;

    logic [ID_W-1:0]     slot_id_reg  [QUEUE_DEPTH];
    logic [TIME_W-1:0]   slot_time_reg[QUEUE_DEPTH];
    logic [URG_W-1:0]    slot_urg_reg [QUEUE_DEPTH];

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [POLICY_W-1:0] policy_mode_reg;
    logic [TIME_W-1:0]   time_slice_reg;

    logic                kind_reg;
    logic [ID_W-1:0]     in_id_reg;
    logic [TIME_W-1:0]   in_time_reg;
    logic [URG_W-1:0]    in_urg_reg;

    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [TIME_W-1:0]   best_key_reg;
    logic [ID_W-1:0]     best_id_reg;
    logic [TIME_W-1:0]   best_time_reg;
    logic [URG_W-1:0]    best_urg_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     chosen_id_reg;
    logic [TIME_W-1:0]   chosen_time_reg;
    logic [URG_W-1:0]    chosen_urg_reg;
    logic [TIME_W-1:0]   granted_slice_reg;
    logic [OCC_W-1:0]    occupancy_reg;

    logic                key_is_time;
    logic                is_full;
    logic                is_empty;
    logic                do_enqueue;
    logic                do_remove;
    logic [TIME_W-1:0]   head_key;
    logic [TIME_W-1:0]   cand_key;
    logic                cand_wins;

    // Shortest remaining ranks by time, priority by urgency; other codes take the head
    assign key_is_time = (policy_mode_reg == POLICY_SRT);
    assign head_key    = key_is_time ? slot_time_reg[0] : TIME_W'(slot_urg_reg[0]);
    assign cand_key    = key_is_time ? slot_time_reg[scan_idx_reg]
                                     : TIME_W'(slot_urg_reg[scan_idx_reg]);
    assign cand_wins   = (cand_key < best_key_reg);

    assign is_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty   = (count_reg == '0);
    assign do_enqueue = cmd.commit && (kind_reg == KIND_ENQUEUE) && !is_full;
    assign do_remove  = cmd.commit && (kind_reg == KIND_SELECT) && !is_empty;

    always_comb
    begin
        stat.needs_scan = (kind == KIND_SELECT) && (count_reg > CNT_W'(1))
                          && ((policy_mode_reg == POLICY_SRT)
                              || (policy_mode_reg == POLICY_PRIO));
        stat.scan_last  = (CNT_W'(scan_idx_reg) == (count_reg - CNT_W'(1)));
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_enqueue)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            policy_mode_reg <= POLICY_RR;
            time_slice_reg  <= TIME_SLICE_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POLICY_MODE: policy_mode_reg <= cfg_data[POLICY_W-1:0];
                    CFG_TIME_SLICE:  time_slice_reg  <= cfg_data[TIME_W-1:0];
                    default:         time_slice_reg  <= time_slice_reg;
                endcase
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the transaction and seed the scan with the head entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= kind;
            in_id_reg     <= task_id;
            in_time_reg   <= time_left;
            in_urg_reg    <= urgency;
            scan_idx_reg  <= IDX_W'(1);
            best_idx_reg  <= '0;
            best_key_reg  <= head_key;
            best_id_reg   <= slot_id_reg[0];
            best_time_reg <= slot_time_reg[0];
            best_urg_reg  <= slot_urg_reg[0];
        end
        else if (cmd.step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            // Strict compare keeps the earliest entry on a tie
            if (cand_wins)
            begin
                best_idx_reg  <= scan_idx_reg;
                best_key_reg  <= cand_key;
                best_id_reg   <= slot_id_reg[scan_idx_reg];
                best_time_reg <= slot_time_reg[scan_idx_reg];
                best_urg_reg  <= slot_urg_reg[scan_idx_reg];
            end
        end
    end

    // Append at the tail, or close the gap left by the removed entry
    always_ff @(posedge clk)
    begin
        if (do_enqueue)
        begin
            slot_id_reg  [count_reg[IDX_W-1:0]] <= in_id_reg;
            slot_time_reg[count_reg[IDX_W-1:0]] <= in_time_reg;
            slot_urg_reg [count_reg[IDX_W-1:0]] <= in_urg_reg;
        end
        else if (do_remove)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                if (IDX_W'(i) >= best_idx_reg)
                begin
                    slot_id_reg[i]   <= slot_id_reg[i+1];
                    slot_time_reg[i] <= slot_time_reg[i+1];
                    slot_urg_reg[i]  <= slot_urg_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg        <= STATUS_ENQUEUED;
            chosen_id_reg     <= '0;
            chosen_time_reg   <= '0;
            chosen_urg_reg    <= '0;
            granted_slice_reg <= '0;
            occupancy_reg     <= OCC_W'(count_next);
            if (kind_reg == KIND_ENQUEUE)
            begin
                status_reg <= is_full ? STATUS_FULL : STATUS_ENQUEUED;
            end
            else if (is_empty)
            begin
                status_reg <= STATUS_EMPTY;
            end
            else
            begin
                status_reg      <= STATUS_SELECTED;
                chosen_id_reg   <= best_id_reg;
                chosen_time_reg <= best_time_reg;
                chosen_urg_reg  <= best_urg_reg;
                if ((policy_mode_reg != POLICY_SRT) && (policy_mode_reg != POLICY_PRIO))
                begin
                    granted_slice_reg <= time_slice_reg;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign chosen_id      = chosen_id_reg;
    assign chosen_time    = chosen_time_reg;
    assign chosen_urgency = chosen_urg_reg;
    assign granted_slice  = granted_slice_reg;
    assign occupancy      = occupancy_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("commit over an unconsumed result");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (CNT_W'(scan_idx_reg) < count_reg))
        else $error("scan index past queued entries");

endmodule

// ----- sv/ready_queue_policy_select.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ready_queue_policy_select: ready queue scheduler with selectable policy
// Enqueue appends a task at the tail; select removes one task by round robin,
// shortest remaining time or lowest priority number, earliest entry on ties.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   in       | in_valid / in_stall   | kind, task_id, time_left, urgency
//   out      | out_valid / out_stall | status, chosen_id, chosen_time,
//            |                       | chosen_urgency, granted_slice, occupancy
//   cfg      | cfg_we                | cfg_index, cfg_data
//
// Enqueue, round robin select (also the unused policy code) and any select over
// fewer than two queued tasks skip the scan; a shortest remaining or priority
// select over n >= 2 queued tasks first scans the slots, one slot per cycle.
// One transaction is in flight at a time.
// Reset empties the queue and loads round robin with a quantum of 4.
// A stalled result holds the block in its commit step until it is taken.
// ============================================================================
module ready_queue_policy_select (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [rqps_pkg::ID_W-1:0]          task_id,
    input  logic [rqps_pkg::TIME_W-1:0]        time_left,
    input  logic [rqps_pkg::URG_W-1:0]         urgency,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rqps_pkg::STATUS_W-1:0]      status,
    output logic [rqps_pkg::ID_W-1:0]          chosen_id,
    output logic [rqps_pkg::TIME_W-1:0]        chosen_time,
    output logic [rqps_pkg::URG_W-1:0]         chosen_urgency,
    output logic [rqps_pkg::TIME_W-1:0]        granted_slice,
    output logic [rqps_pkg::OCC_W-1:0]         occupancy,
    input  logic                               cfg_we,
    input  logic [rqps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rqps_pkg::CFG_W-1:0]         cfg_data
);
    import rqps_pkg::*;

    rqps_cmd_t  cmd;
    rqps_stat_t stat;

    rqps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rqps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .task_id        (task_id),
        .time_left      (time_left),
        .urgency        (urgency),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .chosen_id      (chosen_id),
        .chosen_time    (chosen_time),
        .chosen_urgency (chosen_urgency),
        .granted_slice  (granted_slice),
        .occupancy      (occupancy)
    );

endmodule

// ----- tb/ready_queue_policy_select_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ready_queue_policy_select_checker: result predictor and comparator
// Watches the configuration port and both channels. Each accepted input
// transaction runs through a local copy of the ready queue, and the predicted
// outcome is queued. Each accepted result is compared field by field with the
// oldest prediction. The error count and the number of results still owed are
// handed to the testbench top.
// ============================================================================
module ready_queue_policy_select_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            kind,
    input  logic [rqps_pkg::ID_W-1:0]       task_id,
    input  logic [rqps_pkg::TIME_W-1:0]     time_left,
    input  logic [rqps_pkg::URG_W-1:0]      urgency,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [rqps_pkg::STATUS_W-1:0]   status,
    input  logic [rqps_pkg::ID_W-1:0]       chosen_id,
    input  logic [rqps_pkg::TIME_W-1:0]     chosen_time,
    input  logic [rqps_pkg::URG_W-1:0]      chosen_urgency,
    input  logic [rqps_pkg::TIME_W-1:0]     granted_slice,
    input  logic [rqps_pkg::OCC_W-1:0]      occupancy,
    input  logic                            cfg_we,
    input  logic [rqps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rqps_pkg::CFG_W-1:0]      cfg_data,
    output int                              errors,
    output int                              outstanding
);
    import rqps_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   tm;
        logic [URG_W-1:0]    urg;
        logic [TIME_W-1:0]   slice;
        logic [OCC_W-1:0]    occ;
    } sched_outcome_t;

    logic [ID_W-1:0]     rq_id   [QUEUE_DEPTH];
    logic [TIME_W-1:0]   rq_time [QUEUE_DEPTH];
    logic [URG_W-1:0]    rq_urg  [QUEUE_DEPTH];
    int                  rq_count;
    logic [POLICY_W-1:0] policy;
    logic [TIME_W-1:0]   quantum;

    sched_outcome_t      expected_outcomes[$];
    int                  err_count;

    function automatic sched_outcome_t schedule_item(
        input logic              k,
        input logic [ID_W-1:0]   id,
        input logic [TIME_W-1:0] tl,
        input logic [URG_W-1:0]  ur
    );
        sched_outcome_t r;
        int pick;
        int i;
        r = '0;
        if (k == KIND_ENQUEUE) begin
            if (rq_count >= QUEUE_DEPTH) begin
                r.status = STATUS_FULL;
            end
            else begin
                rq_id[rq_count]   = id;
                rq_time[rq_count] = tl;
                rq_urg[rq_count]  = ur;
                rq_count++;
                r.status = STATUS_ENQUEUED;
            end
        end
        else if (rq_count == 0) begin
            r.status = STATUS_EMPTY;
        end
        else begin
            // strict compare keeps the entry nearest the head on ties
            pick = 0;
            for (i = 1; i < rq_count; i++) begin
                if (policy == POLICY_SRT && rq_time[i] < rq_time[pick])
                    pick = i;
                if (policy == POLICY_PRIO && rq_urg[i] < rq_urg[pick])
                    pick = i;
            end
            r.status = STATUS_SELECTED;
            r.id     = rq_id[pick];
            r.tm     = rq_time[pick];
            r.urg    = rq_urg[pick];
            // unused policy code grants like round robin
            r.slice  = (policy == POLICY_SRT || policy == POLICY_PRIO) ? '0 : quantum;
            for (i = pick; i + 1 < rq_count; i++) begin
                rq_id[i]   = rq_id[i + 1];
                rq_time[i] = rq_time[i + 1];
                rq_urg[i]  = rq_urg[i + 1];
            end
            rq_count--;
        end
        r.occ = rq_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            err_count++;
            if (err_count <= 10)
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        sched_outcome_t exp_o;
        if (!rst_n) begin
            rq_count = 0;
            policy   = POLICY_RR;
            quantum  = TIME_SLICE_RESET;
            expected_outcomes.delete();
            err_count = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_POLICY_MODE)
                    policy = cfg_data[POLICY_W-1:0];
                else if (cfg_index == CFG_TIME_SLICE)
                    quantum = cfg_data[TIME_W-1:0];
            end
            if (in_valid && !in_stall)
                expected_outcomes.push_back(schedule_item(kind, task_id, time_left, urgency));
            if (out_valid && !out_stall) begin
                if (expected_outcomes.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t ns: result transaction with nothing expected, status %0d",
                                 $realtime, status);
                end
                else begin
                    exp_o = expected_outcomes.pop_front();
                    compare_field("status", exp_o.status, status);
                    compare_field("chosen_id", exp_o.id, chosen_id);
                    compare_field("chosen_time", exp_o.tm, chosen_time);
                    compare_field("chosen_urgency", exp_o.urg, chosen_urgency);
                    compare_field("granted_slice", exp_o.slice, granted_slice);
                    compare_field("occupancy", exp_o.occ, occupancy);
                end
            end
            errors      <= err_count;
            outstanding <= expected_outcomes.size();
        end
    end

endmodule

// ----- tb/ready_queue_policy_select_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ready_queue_policy_select_tb: stimulus and verdict for the ready queue
// Drives a directed sequence (empty select, fill to full, overflow, each
// policy, unused policy code, zero and maximum quantum), then random phases
// under changing configuration with random idling on both channels and one
// long result hold-off. The checker beside the block predicts and compares.
// ============================================================================
module ready_queue_policy_select_tb;
    import rqps_pkg::*;

    localparam int PHASES     = 12;
    localparam int PHASE_ITEMS = 135;
    localparam int LONG_HOLD  = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 kind = KIND_ENQUEUE;
    logic [ID_W-1:0]      task_id = '0;
    logic [TIME_W-1:0]    time_left = '0;
    logic [URG_W-1:0]     urgency = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      chosen_id;
    logic [TIME_W-1:0]    chosen_time;
    logic [URG_W-1:0]     chosen_urgency;
    logic [TIME_W-1:0]    granted_slice;
    logic [OCC_W-1:0]     occupancy;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int                   errors;
    int                   outstanding;
    logic                 quiet = 1'b0;
    logic                 hold_req = 1'b0;
    bit                   send_idle = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ready_queue_policy_select uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .task_id(task_id), .time_left(time_left), .urgency(urgency),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .chosen_id(chosen_id), .chosen_time(chosen_time),
        .chosen_urgency(chosen_urgency), .granted_slice(granted_slice),
        .occupancy(occupancy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ready_queue_policy_select_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .task_id(task_id), .time_left(time_left), .urgency(urgency),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .chosen_id(chosen_id), .chosen_time(chosen_time),
        .chosen_urgency(chosen_urgency), .granted_slice(granted_slice),
        .occupancy(occupancy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .outstanding(outstanding)
    );

    // offer one transaction and hold it until the block takes it
    task automatic offer(input logic k, input logic [ID_W-1:0] id,
                         input logic [TIME_W-1:0] tl, input logic [URG_W-1:0] ur);
        int gap;
        gap = 0;
        if (!quiet && send_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        task_id   <= id;
        time_left <= tl;
        urgency   <= ur;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // drop valid and wait for every owed result
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_config(input logic [POLICY_W-1:0] mode, input logic [TIME_W-1:0] q);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLICY_MODE;
        cfg_data  <= CFG_W'(mode);
        @(posedge clk);
        cfg_index <= CFG_TIME_SLICE;
        cfg_data  <= q;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // small values force ties, extremes hit the field limits
    function automatic logic [TIME_W-1:0] shaped(input int unsigned max_v);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return TIME_W'($urandom_range(0, 3));
        else if (r == 3)
            return ($urandom_range(0, 1) != 0) ? TIME_W'(max_v) : '0;
        else
            return TIME_W'($urandom_range(0, max_v));
    endfunction

    task automatic offer_random(input int enq_pct);
        logic             k;
        logic [TIME_W-1:0] tl;
        logic [TIME_W-1:0] ur;
        k  = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQUEUE : KIND_SELECT;
        tl = shaped(65535);
        ur = shaped(255);
        offer(k, ID_W'($urandom), tl, ur[URG_W-1:0]);
    endtask

    initial
    begin : result_side
        int burst;
        int stretch;
        bit active;
        bit held;
        held    = 1'b0;
        active  = 1'b1;
        stretch = 0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else begin
                if (stretch == 0) begin
                    active  = $urandom_range(0, 1);
                    stretch = $urandom_range(50, 300);
                end
                else begin
                    stretch--;
                end
                if (active && !quiet && $urandom_range(0, 5) == 0) begin
                    burst = $urandom_range(1, 15);
                    out_stall <= 1'b1;
                    repeat (burst) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin : stimulus
        int n;
        int ph;
        int enq_pct;
        logic [POLICY_W-1:0] mode;
        logic [TIME_W-1:0]   q;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty select, fill with ties and extremes, overflow
        offer(KIND_SELECT, 8'hFF, 16'hFFFF, 8'hFF);
        for (n = 0; n < QUEUE_DEPTH; n++)
            offer(KIND_ENQUEUE,
                  (n == QUEUE_DEPTH - 1) ? 8'hFF : ID_W'(n * 16),
                  (n == 0) ? 16'hFFFF : ((n % 3 == 1) ? 16'd0 : TIME_W'(1000 * n)),
                  (n == 2) ? 8'hFF : ((n % 4 == 3) ? 8'd0 : URG_W'(100 + n)));
        offer(KIND_ENQUEUE, 8'hAA, 16'h5555, 8'h55);
        write_config(POLICY_SRT, 16'd4);
        offer(KIND_SELECT, 8'h00, 16'h0000, 8'h00);
        offer(KIND_SELECT, 8'h00, 16'h0000, 8'h00);
        write_config(POLICY_PRIO, 16'd4);
        offer(KIND_SELECT, 8'h00, 16'h0000, 8'h00);
        offer(KIND_SELECT, 8'h00, 16'h0000, 8'h00);
        // unused policy code with a zero quantum
        write_config(POLICY_RESERVED, 16'd0);
        offer(KIND_SELECT, 8'h00, 16'h0000, 8'h00);
        write_config(POLICY_RR, 16'hFFFF);
        offer(KIND_SELECT, 8'h00, 16'h0000, 8'h00);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       begin mode = POLICY_RR;       q = 16'd1;             end
                1:       begin mode = POLICY_SRT;      q = TIME_W'($urandom); end
                2:       begin mode = POLICY_PRIO;     q = 16'hFFFF;          end
                3:       begin mode = POLICY_RESERVED; q = TIME_W'($urandom); end
                4:       begin mode = POLICY_RR;       q = 16'd0;             end
                default: begin
                    mode = POLICY_W'($urandom_range(0, 3));
                    q    = ($urandom_range(0, 3) == 0) ? 16'hFFFF : TIME_W'($urandom);
                end
            endcase
            write_config(mode, q);
            case ($urandom_range(0, 3))
                0:       enq_pct = 20;
                1:       enq_pct = 50;
                2:       enq_pct = 65;
                default: enq_pct = 85;
            endcase
            send_idle = ($urandom_range(0, 2) != 0);
            if (ph == 5) begin
                // block fills up behind a long result hold-off
                enq_pct = 85;
                hold_req <= 1'b1;
            end
            if (ph == PHASES - 1) begin
                quiet <= 1'b1;
                send_idle = 1'b0;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 45 == 44 && ph != PHASES - 1)
                    send_idle = ($urandom_range(0, 2) != 0);
                offer_random(enq_pct);
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("ready_queue_policy_select verification clean");
        else
            $display("ready_queue_policy_select verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #(12 * 800000);
        $display("ready_queue_policy_select verification failed");
        $finish;
    end

endmodule
